FILE: src/gcdp_pkg.sv
// ----------------------------------------------------------------------------
// gcdp_pkg
// Shared constants, the CORDIC arctangent table and the Q30 product helper
// for the great-circle destination point core.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdp_pkg;

    // field widths
    localparam int LAT_W  = 30;
    localparam int LNG_W  = 31;
    localparam int DIST_W = 25;
    localparam int HDG_W  = 31;
    localparam int DLAT_W = 30;
    localparam int DLNG_W = 32;
    localparam int RAD_W  = 24;

    // stream packing
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 64;
    localparam int LAT_LSB   = 0;
    localparam int LNG_LSB   = LAT_LSB + LAT_W;
    localparam int DIST_LSB  = LNG_LSB + LNG_W;
    localparam int HDG_LSB   = DIST_LSB + DIST_W;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd6371000;

    // degrees
    localparam int HALF_TURN_DEG = 180;
    localparam int FULL_TURN_DEG = 2 * HALF_TURN_DEG;
    localparam int QTR_TURN_DEG  = HALF_TURN_DEG / 2;

    // turns per radian, Q8
    localparam int               TPR_W            = 38;
    localparam logic [TPR_W-1:0] TURNS_PER_RAD_Q8 = 38'd174992710548;
    localparam int               KSPLIT           = 19;
    localparam int               PROD_W           = DIST_W + TPR_W;
    localparam int               PPART_W          = DIST_W + KSPLIT;

    // datapath widths
    localparam int SC_W  = 34;   // sincos x/y/z
    localparam int AT_W  = 36;   // atan2 x/y
    localparam int Q_W   = 32;   // Q30 trig values
    localparam int SQ_W  = 61;   // square-root operand
    localparam int SQR_W = 31;   // square-root stages (bit 2^60 down to 2^0)

    localparam logic signed [SC_W-1:0] KINV_Q30 = 34'sd652032874;
    localparam logic signed [Q_W-1:0]  ONE_Q30  = 32'sd1073741824;

    // arctangent of 2^-i in binary turns (2^32 per turn)
    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up
    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        logic signed [63:0] p;
        ae = a;
        be = b;
        p  = ae * be + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

`default_nettype wire

FILE: src/great_circle_destination_point_core.sv
// ----------------------------------------------------------------------------
// great_circle_destination_point_core
// Destination point on a sphere from start point, distance and bearing.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : input stream, one transaction per point (lat, lng, distance, bearing).
//   m_* : output stream, one transaction per input (dest lat, unwrapped lng).
//   cfg_*: radius write channel, always ready; write only while the core is
//          empty. A radius of zero is used as one meter.
// Datapath: the 63-step distance/radius divider, two CORDIC banks, and
//   the 31-step square root between them.
// Throughput: one transaction per cycle unless the output stalls; every
//   stage is a register stage and the whole pipeline advances on a single enable.
// Reset: valid bits clear, radius returns to 6371000 m. Datapath registers
//   are not reset; only valid bits mark live data.
// Stall: when the output holds a result that m_tready does not take, the
//   whole pipeline freezes and s_tready drops in the same cycle; nothing is
//   lost or repeated, and the output register keeps its transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_destination_point_core #(
    parameter int ANGLE_FRAC_BITS = 22,
    parameter int CORDIC_STAGES   = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // radius write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gcdp_pkg::RAD_W-1:0]       cfg_data,   // sphere_radius_m
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // start_lat[29:0], start_lng[60:30], travel_m[85:61], heading[116:86], 0s
    input  wire logic [gcdp_pkg::S_TDATA_W-1:0]   s_tdata,
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // dest_lat[29:0], dest_lng[61:30], 0s
    output logic [gcdp_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int CS   = CORDIC_STAGES;
    localparam int PW   = gcdp_pkg::PROD_W;           // distance divider steps
    localparam int DSH  = 32 - ANGLE_FRAC_BITS;       // degrees -> turns shift
    localparam int RW   = gcdp_pkg::RAD_W;
    localparam int SCW  = gcdp_pkg::SC_W;
    localparam int ATW  = gcdp_pkg::AT_W;
    localparam int QW   = gcdp_pkg::Q_W;
    localparam int SQW  = gcdp_pkg::SQ_W;
    localparam int SQN  = gcdp_pkg::SQR_W;
    // degree conversion: 360 = 8 * 45, both divides by 45 by reciprocal
    localparam int MW      = gcdp_pkg::HDG_W;         // angle magnitude width
    localparam int DSH3    = DSH - 3;
    localparam int RCP_SH1 = 37;
    localparam int RCP_SH2 = 25;
    localparam int DP1_W   = MW + 32;
    localparam int DQ_W    = DP1_W - RCP_SH1;
    localparam int DX_W    = 19;
    localparam int DP2_W   = DX_W + 20;
    localparam logic [31:0]     RCP45_Q37 = 32'd3054198967;
    localparam logic [19:0]     RCP45_Q25 = 20'd745655;
    localparam logic [MW-1:0]   DEG_DIV   = MW'(gcdp_pkg::FULL_TURN_DEG / 8);
    localparam logic [DX_W-1:0] DEG_BIAS  = DX_W'(gcdp_pkg::HALF_TURN_DEG / 8);
    // stage indexes along the valid chain
    localparam int ST_SC  = 2 + PW;                   // sincos pre-rotation
    localparam int ST_POST = ST_SC + CS + 1;
    localparam int ST_M1  = ST_POST + 1;
    localparam int L      = ST_M1 + 5 + SQN + 1 + CS + 2;

    localparam logic [gcdp_pkg::KSPLIT-1:0] TPR_LO =
        gcdp_pkg::TURNS_PER_RAD_Q8[gcdp_pkg::KSPLIT-1:0];
    localparam logic [gcdp_pkg::TPR_W-gcdp_pkg::KSPLIT-1:0] TPR_HI =
        gcdp_pkg::TURNS_PER_RAD_Q8[gcdp_pkg::TPR_W-1:gcdp_pkg::KSPLIT];
    localparam logic signed [63:0] DEG_SCALE =
        64'(gcdp_pkg::FULL_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic signed [63:0] LAT_LIM =
        64'(gcdp_pkg::QTR_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic signed [63:0] RND32 = 64'sd2147483648;

    // ------------------------------------------------------------------
    // control: single pipeline enable, valid chain, radius register
    // ------------------------------------------------------------------
    logic                 en;
    logic                 vld_reg [0:L-1];
    logic signed [gcdp_pkg::LNG_W-1:0] lng_reg [0:L-2];
    logic [RW-1:0]        radius_reg;
    logic [RW-1:0]        rad_eff;

    assign en        = !vld_reg[L-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[L-1];
    assign rad_eff   = (radius_reg == '0) ? RW'(1) : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= gcdp_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < L; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // start longitude rides alongside until the final sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lng_reg[0] <= s_tdata[gcdp_pkg::LNG_LSB +: gcdp_pkg::LNG_W];
            for (int k = 1; k < L-1; k++)
            begin
                lng_reg[k] <= lng_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage A: distance * turns-per-radian partial products,
    //          latitude magnitude and bearing
    // ------------------------------------------------------------------
    logic signed [gcdp_pkg::LAT_W-1:0]    lat_in;
    logic [gcdp_pkg::LAT_W-1:0]           lat_mag;
    logic [gcdp_pkg::DIST_W-1:0]          dist_in;
    logic [gcdp_pkg::HDG_W-1:0]           hdg_in;
    logic [gcdp_pkg::PPART_W-1:0]         ph_next, pl_next, ph_reg, pl_reg;
    logic [MW-1:0]                        latm_next, latm_reg, brgm_reg;
    logic                                 latneg_next, latneg_reg;

    always_comb
    begin
        lat_in      = s_tdata[gcdp_pkg::LAT_LSB +: gcdp_pkg::LAT_W];
        dist_in     = s_tdata[gcdp_pkg::DIST_LSB +: gcdp_pkg::DIST_W];
        hdg_in      = s_tdata[gcdp_pkg::HDG_LSB +: gcdp_pkg::HDG_W];
        latneg_next = lat_in[gcdp_pkg::LAT_W-1];
        lat_mag     = latneg_next ? gcdp_pkg::LAT_W'(-lat_in) : lat_in;
        latm_next   = MW'(lat_mag);
        ph_next     = gcdp_pkg::PPART_W'(dist_in) * gcdp_pkg::PPART_W'(TPR_HI);
        pl_next     = gcdp_pkg::PPART_W'(dist_in) * gcdp_pkg::PPART_W'(TPR_LO);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            latm_reg   <= latm_next;
            brgm_reg   <= hdg_in;
            latneg_reg <= latneg_next;
        end
    end

    // ------------------------------------------------------------------
    // degrees to turns, channel 0 latitude, 1 bearing:
    //   floor((m*2^DSH + 180) / 360) = floor((m*2^(DSH-3) + 22) / 45)
    //   with m = 45*q + r this is q*2^(DSH-3) + floor((r*2^(DSH-3) + 22) / 45)
    // three stages, then delayed to line up with the distance quotient
    // ------------------------------------------------------------------
    logic [MW-1:0] dg_mag [0:1];
    logic          dg_neg [0:1];
    logic [31:0]   tw_reg [0:PW-2][0:1];

    assign dg_mag[0] = latm_reg;
    assign dg_neg[0] = latneg_reg;
    assign dg_mag[1] = brgm_reg;
    assign dg_neg[1] = 1'b0;

    for (genvar c = 0; c < 2; c++)
    begin : g_deg
        logic [DP1_W-1:0] p1;
        logic [DQ_W-1:0]  q1_reg, q2_reg;
        logic [MW-1:0]    m1_reg;
        logic [MW-1:0]    r1;
        logic [DX_W-1:0]  x_next, x_reg;
        logic [DP2_W-1:0] p2;
        logic             n1_reg, n2_reg;
        logic [31:0]      tw_mag, tw_next;

        always_comb
        begin
            p1      = DP1_W'(dg_mag[c]) * DP1_W'(RCP45_Q37);
            r1      = m1_reg - MW'(MW'(q1_reg) * DEG_DIV);
            x_next  = (DX_W'(r1[5:0]) << DSH3) + DEG_BIAS;
            p2      = DP2_W'(x_reg) * DP2_W'(RCP45_Q25);
            tw_mag  = (32'(q2_reg) << DSH3) + 32'(p2[DP2_W-1:RCP_SH2]);
            tw_next = n2_reg ? 32'd0 - tw_mag : tw_mag;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q1_reg       <= p1[DP1_W-1:RCP_SH1];
                m1_reg       <= dg_mag[c];
                n1_reg       <= dg_neg[c];
                q2_reg       <= q1_reg;
                x_reg        <= x_next;
                n2_reg       <= n1_reg;
                tw_reg[0][c] <= tw_next;
                for (int k = 1; k < PW-1; k++)
                begin
                    tw_reg[k][c] <= tw_reg[k-1][c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage B + divider: floor(dist*K / R) one bit per stage
    // ------------------------------------------------------------------
    logic [PW-1:0]  dw_reg   [0:PW];
    logic [RW-1:0]  drem_reg [0:PW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dw_reg[0]   <= PW'((PW'(ph_reg) << gcdp_pkg::KSPLIT) + PW'(pl_reg));
            drem_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < PW; i++)
    begin : g_div
        logic [RW:0]   dt;
        logic          dge;
        logic [PW-1:0] dw_next;
        logic [RW-1:0] drem_next;

        always_comb
        begin
            dt        = {drem_reg[i], dw_reg[i][PW-1]};
            dge       = dt >= {1'b0, rad_eff};
            drem_next = dge ? RW'(dt - {1'b0, rad_eff}) : dt[RW-1:0];
            dw_next   = {dw_reg[i][PW-2:0], dge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dw_reg[i+1]   <= dw_next;
                drem_reg[i+1] <= drem_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // sincos bank: channel 0 latitude, 1 angular distance, 2 bearing
    // ------------------------------------------------------------------
    logic [31:0]            sc_ang [0:2];
    logic signed [SCW-1:0]  scx_reg [0:CS][0:2];
    logic signed [SCW-1:0]  scy_reg [0:CS][0:2];
    logic signed [SCW-1:0]  scz_reg [0:CS][0:2];
    logic                   scf_reg [0:CS][0:2];
    logic signed [QW-1:0]   cos_reg [0:2];
    logic signed [QW-1:0]   sin_reg [0:2];

    always_comb
    begin
        sc_ang[0] = tw_reg[PW-2][0];
        sc_ang[1] = dw_reg[PW][39:8];
        sc_ang[2] = tw_reg[PW-2][1];
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_sc
        logic [31:0] rot;
        logic        flip_next;
        logic [31:0] t;

        // fold the angle into +-quarter turn, flip the result back at the end
        always_comb
        begin
            rot       = sc_ang[c] + 32'h4000_0000;
            flip_next = rot[31];
            t         = flip_next ? sc_ang[c] - 32'h8000_0000 : sc_ang[c];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                scx_reg[0][c] <= gcdp_pkg::KINV_Q30;
                scy_reg[0][c] <= '0;
                scz_reg[0][c] <= SCW'($signed(t));
                scf_reg[0][c] <= flip_next;
            end
        end

        for (genvar i = 0; i < CS; i++)
        begin : g_st
            localparam logic signed [SCW-1:0] AT =
                $signed({2'b00, gcdp_pkg::atan_at(i)});
            logic signed [SCW-1:0] x_next, y_next, z_next;
            always_comb
            begin
                if (!scz_reg[i][c][SCW-1])
                begin
                    x_next = scx_reg[i][c] - (scy_reg[i][c] >>> i);
                    y_next = scy_reg[i][c] + (scx_reg[i][c] >>> i);
                    z_next = scz_reg[i][c] - AT;
                end
                else
                begin
                    x_next = scx_reg[i][c] + (scy_reg[i][c] >>> i);
                    y_next = scy_reg[i][c] - (scx_reg[i][c] >>> i);
                    z_next = scz_reg[i][c] + AT;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    scx_reg[i+1][c] <= x_next;
                    scy_reg[i+1][c] <= y_next;
                    scz_reg[i+1][c] <= z_next;
                    scf_reg[i+1][c] <= scf_reg[i][c];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cos_reg[c] <= scf_reg[CS][c] ? QW'(-scx_reg[CS][c]) : QW'(scx_reg[CS][c]);
                sin_reg[c] <= scf_reg[CS][c] ? QW'(-scy_reg[CS][c]) : QW'(scy_reg[CS][c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // product stages
    //   s   = sl*cd + (cl*sd)*cb, clamped to +-1
    //   num = (sb*sd)*cl,  den = cd - sl*s
    // ------------------------------------------------------------------
    logic signed [QW-1:0] m1_p1_reg, m1_p2_reg, m1_p4_reg, m1_cl_reg, m1_sl_reg;
    logic signed [QW-1:0] m1_cd_reg, m1_cb_reg;
    logic signed [QW-1:0] m2_p1_reg, m2_p3_reg, m2_num_reg, m2_sl_reg, m2_cd_reg;
    logic signed [QW-1:0] m3_s_reg, m3_num_reg, m3_sl_reg, m3_cd_reg;
    logic signed [QW:0]   s_sum;
    logic signed [QW-1:0] s_next;
    logic [SQW-1:0]       m4_ss_reg;
    logic signed [QW-1:0] m4_sls_reg, m4_s_reg, m4_num_reg, m4_cd_reg;
    logic signed [63:0]   s_wide;
    logic signed [63:0]   ss_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_p1_reg <= gcdp_pkg::mulq(sin_reg[0], cos_reg[1]);
            m1_p2_reg <= gcdp_pkg::mulq(cos_reg[0], sin_reg[1]);
            m1_p4_reg <= gcdp_pkg::mulq(sin_reg[2], sin_reg[1]);
            m1_cl_reg <= cos_reg[0];
            m1_sl_reg <= sin_reg[0];
            m1_cd_reg <= cos_reg[1];
            m1_cb_reg <= cos_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_p1_reg  <= m1_p1_reg;
            m2_p3_reg  <= gcdp_pkg::mulq(m1_p2_reg, m1_cb_reg);
            m2_num_reg <= gcdp_pkg::mulq(m1_p4_reg, m1_cl_reg);
            m2_sl_reg  <= m1_sl_reg;
            m2_cd_reg  <= m1_cd_reg;
        end
    end

    always_comb
    begin
        s_sum = (QW+1)'(m2_p1_reg) + (QW+1)'(m2_p3_reg);
        if (s_sum > (QW+1)'(gcdp_pkg::ONE_Q30))
        begin
            s_next = gcdp_pkg::ONE_Q30;
        end
        else if (s_sum < -(QW+1)'(gcdp_pkg::ONE_Q30))
        begin
            s_next = -gcdp_pkg::ONE_Q30;
        end
        else
        begin
            s_next = s_sum[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_s_reg   <= s_next;
            m3_num_reg <= m2_num_reg;
            m3_sl_reg  <= m2_sl_reg;
            m3_cd_reg  <= m2_cd_reg;
        end
    end

    always_comb
    begin
        s_wide  = m3_s_reg;
        ss_next = s_wide * s_wide;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_ss_reg  <= ss_next[SQW-1:0];
            m4_sls_reg <= gcdp_pkg::mulq(m3_sl_reg, m3_s_reg);
            m4_s_reg   <= m3_s_reg;
            m4_num_reg <= m3_num_reg;
            m4_cd_reg  <= m3_cd_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root of 1 - s^2 (Q60), one result bit per stage
    // ------------------------------------------------------------------
    logic [SQW-1:0]        sqn_reg   [0:SQN];
    logic [SQW-1:0]        sqr_reg   [0:SQN];
    logic signed [QW-1:0]  sqs_reg   [0:SQN];
    logic signed [QW-1:0]  sqnum_reg [0:SQN];
    logic signed [QW:0]    sqden_reg [0:SQN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqn_reg[0]   <= (SQW'(1) << 60) - m4_ss_reg;
            sqr_reg[0]   <= '0;
            sqs_reg[0]   <= m4_s_reg;
            sqnum_reg[0] <= m4_num_reg;
            sqden_reg[0] <= (QW+1)'(m4_cd_reg) - (QW+1)'(m4_sls_reg);
        end
    end

    for (genvar j = 0; j < SQN; j++)
    begin : g_sqrt
        localparam logic [SQW:0] BIT = (SQW+1)'(1) << (60 - 2*j);
        logic [SQW:0]   trial;
        logic [SQW-1:0] n_next, r_next;
        always_comb
        begin
            trial = {1'b0, sqr_reg[j]} + BIT;
            if ({1'b0, sqn_reg[j]} >= trial)
            begin
                n_next = SQW'({1'b0, sqn_reg[j]} - trial);
                r_next = SQW'((sqr_reg[j] >> 1) + BIT[SQW-1:0]);
            end
            else
            begin
                n_next = sqn_reg[j];
                r_next = sqr_reg[j] >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqn_reg[j+1]   <= n_next;
                sqr_reg[j+1]   <= r_next;
                sqs_reg[j+1]   <= sqs_reg[j];
                sqnum_reg[j+1] <= sqnum_reg[j];
                sqden_reg[j+1] <= sqden_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // atan2 bank: channel 0 asin via atan2(s, c), channel 1 longitude change
    // ------------------------------------------------------------------
    logic signed [ATW-1:0] at_xin [0:1];
    logic signed [ATW-1:0] at_yin [0:1];
    logic signed [ATW-1:0] atx_reg [0:CS][0:1];
    logic signed [ATW-1:0] aty_reg [0:CS][0:1];
    logic [31:0]           atz_reg [0:CS][0:1];
    logic signed [63:0]    tprod_reg [0:1];

    always_comb
    begin
        at_xin[0] = ATW'($signed({1'b0, sqr_reg[SQN][SQN:0]}));
        at_yin[0] = ATW'(sqs_reg[SQN]);
        at_xin[1] = ATW'(sqden_reg[SQN]);
        at_yin[1] = ATW'(sqnum_reg[SQN]);
    end

    for (genvar c = 0; c < 2; c++)
    begin : g_at
        logic xneg;
        assign xneg = at_xin[c][ATW-1];

        // left half-plane: rotate by half a turn first
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                atx_reg[0][c] <= xneg ? -at_xin[c] : at_xin[c];
                aty_reg[0][c] <= xneg ? -at_yin[c] : at_yin[c];
                atz_reg[0][c] <= xneg ? 32'h8000_0000 : 32'd0;
            end
        end

        for (genvar i = 0; i < CS; i++)
        begin : g_st
            localparam logic [31:0] AT = gcdp_pkg::atan_at(i);
            logic signed [ATW-1:0] x_next, y_next;
            logic [31:0]           z_next;
            always_comb
            begin
                if (aty_reg[i][c][ATW-1])
                begin
                    x_next = atx_reg[i][c] - (aty_reg[i][c] >>> i);
                    y_next = aty_reg[i][c] + (atx_reg[i][c] >>> i);
                    z_next = atz_reg[i][c] - AT;
                end
                else
                begin
                    x_next = atx_reg[i][c] + (aty_reg[i][c] >>> i);
                    y_next = aty_reg[i][c] - (atx_reg[i][c] >>> i);
                    z_next = atz_reg[i][c] + AT;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    atx_reg[i+1][c] <= x_next;
                    aty_reg[i+1][c] <= y_next;
                    atz_reg[i+1][c] <= z_next;
                end
            end
        end

        // turns to degrees, scaled product
        logic signed [63:0] zt;
        assign zt = $signed(atz_reg[CS][c]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tprod_reg[c] <= zt * DEG_SCALE;
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: round, clamp latitude, add longitude change
    // ------------------------------------------------------------------
    logic signed [63:0]                 lat_deg, lng_deg;
    logic signed [63:0]                 lat_clamp;
    logic [gcdp_pkg::DLAT_W-1:0]        dlat_next, dlat_reg;
    logic [gcdp_pkg::DLNG_W-1:0]        dlng_next, dlng_reg;

    always_comb
    begin
        lat_deg = (tprod_reg[0] + RND32) >>> 32;
        lng_deg = (tprod_reg[1] + RND32) >>> 32;
        if (lat_deg > LAT_LIM)
        begin
            lat_clamp = LAT_LIM;
        end
        else if (lat_deg < -LAT_LIM)
        begin
            lat_clamp = -LAT_LIM;
        end
        else
        begin
            lat_clamp = lat_deg;
        end
        dlat_next = lat_clamp[gcdp_pkg::DLAT_W-1:0];
        dlng_next = gcdp_pkg::DLNG_W'(lng_reg[L-2]) + lng_deg[gcdp_pkg::DLNG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_reg <= dlat_next;
            dlng_reg <= dlng_next;
        end
    end

    assign m_tdata = {2'b00, dlng_reg, dlat_reg};

endmodule

`default_nettype wire

FILE: verif/tb_great_circle_destination_point_core.sv
// ----------------------------------------------------------------------------
// tb_great_circle_destination_point_core
// Streams start points, distances and bearings into the destination point
// core under several sphere radii and compares every result transaction
// against an in-bench fixed-point predictor of the spherical formulas.
// ----------------------------------------------------------------------------
module tb_great_circle_destination_point_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = 24;
    localparam int FRAC      = 22;
    localparam int LATENCY   = 106 + 2 * STAGES;
    localparam longint LIMIT = 400000;
    localparam longint KINV  = 64'sd652032874;
    localparam longint TPR   = 64'd174992710548;
    localparam longint LAT_MAX = 64'sd377487360;
    localparam longint LNG_MAX = 64'sd754974720;
    localparam longint HDG_MAX = 64'sd1509949440;

    typedef struct packed {
        logic [gcdp_pkg::DLNG_W-1:0] lng;
        logic [gcdp_pkg::DLAT_W-1:0] lat;
    } dest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gcdp_pkg::RAD_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [gcdp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [gcdp_pkg::M_TDATA_W-1:0] m_tdata;

    // predictor copy of the radius register
    logic [gcdp_pkg::RAD_W-1:0] radius_m = gcdp_pkg::RADIUS_RESET;
    dest_t dest_queue[$];
    int mismatches = 0;
    int results_seen = 0;
    int out_wait = 0;
    longint cycles = 0;
    bit draining = 1'b0;

    great_circle_destination_point_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint arith_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint turns_sgn(logic [31:0] t);
        return longint'(signed'(t));
    endfunction

    function automatic longint atan_turn(int i);
        longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1, 1, 0};
        return (i < 32) ? tbl[i] : 0;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return arith_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // degrees*2^22 to binary turns, halves away from zero
    function automatic logic [31:0] deg2turn(longint v);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = ((mag << (32 - FRAC)) + 180) / 360;
        if (v < 0)
            q = -q;
        return q[31:0];
    endfunction

    function automatic longint turn2deg(longint t);
        return arith_shr(t * (longint'(360) <<< FRAC) + (64'sd1 <<< 31), 32);
    endfunction

    task automatic rotate_sincos(input logic [31:0] a, output longint c, output longint s);
        bit flip;
        logic [31:0] t;
        longint z, x, y, dx, dy;
        t = a + 32'h4000_0000;
        flip = t[31];
        t = flip ? a - 32'h8000_0000 : a;
        z = turns_sgn(t);
        x = KINV;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = arith_shr(y, i);
            dy = arith_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_turn(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_turn(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vector_angle(longint y, longint x);
        logic [31:0] z;
        longint dx, dy;
        z = 0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = arith_shr(y, i);
            dy = arith_shr(x, i);
            if (y < 0)
            begin
                x -= dx; y += dy; z -= atan_turn(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_turn(i);
            end
        end
        return turns_sgn(z);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_destination(input logic [gcdp_pkg::S_TDATA_W-1:0] d,
                                       output dest_t res);
        longint lat1, lng1, brg, cl, sl, cd, sd, cb, sb, s, c, lat2, num, den, dlng, ld;
        longint unsigned dist_m, r, acc;
        lat1 = longint'(signed'(d[gcdp_pkg::LAT_LSB +: gcdp_pkg::LAT_W]));
        lng1 = longint'(signed'(d[gcdp_pkg::LNG_LSB +: gcdp_pkg::LNG_W]));
        dist_m = d[gcdp_pkg::DIST_LSB +: gcdp_pkg::DIST_W];
        brg = longint'(d[gcdp_pkg::HDG_LSB +: gcdp_pkg::HDG_W]);
        r = (radius_m == 0) ? 1 : radius_m;
        acc = (dist_m / r) * TPR + ((dist_m % r) * TPR) / r;
        rotate_sincos(deg2turn(lat1), cl, sl);
        rotate_sincos(acc[39:8], cd, sd);
        rotate_sincos(deg2turn(brg), cb, sb);
        s = q30_mul(sl, cd) + q30_mul(q30_mul(cl, sd), cb);
        if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        lat2 = vector_angle(s, c);
        num = q30_mul(q30_mul(sb, sd), cl);
        den = cd - q30_mul(sl, s);
        dlng = vector_angle(num, den);
        ld = turn2deg(lat2);
        if (ld > LAT_MAX) ld = LAT_MAX;
        if (ld < -LAT_MAX) ld = -LAT_MAX;
        res.lat = ld[gcdp_pkg::DLAT_W-1:0];
        ld = lng1 + turn2deg(dlng);
        res.lng = ld[gcdp_pkg::DLNG_W-1:0];
    endtask

    // ---------------- stimulus helpers ----------------
    // s_tvalid stays high into a back-to-back transaction; it drops before a gap
    task automatic send_point(input longint lat, input longint lng, input longint travel,
                              input longint hdg);
        logic [gcdp_pkg::S_TDATA_W-1:0] d;
        dest_t res;
        int gap;
        d = '0;
        d[gcdp_pkg::LAT_LSB +: gcdp_pkg::LAT_W] = lat[gcdp_pkg::LAT_W-1:0];
        d[gcdp_pkg::LNG_LSB +: gcdp_pkg::LNG_W] = lng[gcdp_pkg::LNG_W-1:0];
        d[gcdp_pkg::DIST_LSB +: gcdp_pkg::DIST_W] = travel[gcdp_pkg::DIST_W-1:0];
        d[gcdp_pkg::HDG_LSB +: gcdp_pkg::HDG_W] = hdg[gcdp_pkg::HDG_W-1:0];
        predict_destination(d, res);
        dest_queue.push_back(res);
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // radius writes only with the pipeline empty
    task automatic write_radius(input logic [gcdp_pkg::RAD_W-1:0] r);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_m = r;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (dest_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic longint rand_signed(longint maxv);
        return longint'($urandom_range(0, 2 * maxv)) - maxv;
    endfunction

    task automatic send_random(input int n, input longint max_dist);
        for (int i = 0; i < n; i++)
            send_point(rand_signed(LAT_MAX), rand_signed(LNG_MAX),
                       $urandom_range(0, max_dist), $urandom_range(0, HDG_MAX));
    endtask

    // ---------------- test tasks ----------------
    task automatic test_directed_extremes();
        send_point(0, 0, 0, 0);
        send_point(LAT_MAX, LNG_MAX, 1000, 0);
        send_point(-LAT_MAX, -LNG_MAX, 1000, HDG_MAX / 2);
        send_point(0, 0, 33554431, HDG_MAX);
        send_point(0, 0, 10007543, 0);                 // about a quarter turn
        send_point(LAT_MAX - 5, 12345, 20015086, 0);   // overshoot across the pole
        send_point(-377487359, -1, 1, HDG_MAX / 4);
        send_point(-(64'sd1 <<< 29), -(64'sd1 <<< 30), 5000000, 377487360);
        send_point((64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1, 33554431, 1132462080);
        send_point(0, LNG_MAX, 20015086, HDG_MAX / 4); // antipode
        send_point(12345678, -54321, 777777, 2147483647); // bearing beyond a turn
        send_point(0, 0, 0, 2147483647);
    endtask

    task automatic test_radius_extremes();
        write_radius(24'd0);                      // zero behaves as one meter
        send_point(100000, 2000, 3, 5000000);
        send_point(-100000, 2000, 33554431, 600000000);
        write_radius(24'd1);
        send_point(300000000, -700000000, 33554431, HDG_MAX);
        send_random(30, 33554431);
        write_radius(24'hFFFFFF);
        send_point(LAT_MAX, LNG_MAX, 33554431, 0);
        send_random(40, 33554431);
    endtask

    task automatic test_random_earth();
        write_radius(gcdp_pkg::RADIUS_RESET);
        send_random(300, 33554431);
        send_random(100, 100000);
    endtask

    task automatic test_random_radii();
        for (int k = 0; k < 6; k++)
        begin
            write_radius($urandom_range(1, 24'hFFFFFF));
            send_random(60, 33554431);
        end
    endtask

    // ---------------- result checking ----------------
    // after each result transaction the receiver may pause m_tready at random; while draining it stays ready
    always @(posedge clk)
    begin
        int nw;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                nw = draining ? 0 : $urandom_range(0, 9);
                out_wait <= nw;
                m_tready <= (nw == 0);
            end
            else if (out_wait > 0)
            begin
                out_wait <= out_wait - 1;
                m_tready <= (out_wait == 1);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        dest_t got;
        dest_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[gcdp_pkg::DLAT_W + gcdp_pkg::DLNG_W - 1:0];
            results_seen <= results_seen + 1;
            if (dest_queue.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result transaction %h", m_tdata);
            end
            else
            begin
                want = dest_queue.pop_front();
                if (got.lat !== want.lat || got.lng !== want.lng)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result %0d: lat exp %h got %h, lng exp %h got %h",
                                 results_seen, want.lat, got.lat, want.lng, got.lng);
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_radius_extremes();
        test_random_earth();
        test_random_radii();
        draining = 1'b1;
        wait_idle();
        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d results over zero, minimum, maximum and random radii",
                 results_seen);
        $display("with directed pole, antipode and out-of-range bearing cases");
        if (mismatches == 0 && dest_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
